[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Implication checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rst, ante, cons)
`define ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

[hw/rtl/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types, constants and helpers of the sprite quad setup block.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int CMD_DEPTH_DEF    = 4;
  localparam int OUT_DEPTH_DEF    = 4;

  localparam int CW    = 38;  // CORDIC x/y width
  localparam int ZW    = 34;  // CORDIC angle accumulator width
  localparam int MW    = 33;  // multiplier operand width
  localparam int PW    = 66;  // product width
  localparam int AW    = 68;  // accumulator width
  localparam int SAT_W = 40;  // saturation input width

  localparam logic [1:0] OP_LINE    = 2'd0;
  localparam logic [1:0] OP_FILL    = 2'd1;
  localparam logic [1:0] OP_OUTLINE = 2'd2;

  localparam logic signed [CW-1:0] GAIN_Q30 = 38'sd652032874;
  localparam logic signed [CW-1:0] ONE_Q30  = 38'sd1073741824;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [15:0] rot;
    logic [30:0]        thick;
    logic [31:0]        color;
    logic [15:0]        depth;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] w;
    logic signed [31:0] h;
    logic signed [15:0] angle;
    logic [31:0]        color;
    logic [15:0]        depth;
    logic               last;
  } quad_t;

  typedef struct packed {
    logic               start;
    logic               vec;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [31:0]        a;
  } cordic_req_t;

  typedef struct packed {
    logic               done;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RROT_GO,
    ST_RROT_WAIT,
    ST_RECT_MUL,
    ST_FILL,
    ST_CORNER,
    ST_VEC_GO,
    ST_VEC_WAIT,
    ST_LEN_MUL,
    ST_LROT_GO,
    ST_LROT_WAIT,
    ST_T_MUL,
    ST_EMIT
  } back_state_t;

  function automatic logic [31:0] atan_val(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [31:0] r;
    if (v > 40'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -40'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[hw/rtl/shape_primitive_to_sprite_quads_top.sv]
// ----------------------------------------------------------------------------
// shape_primitive_to_sprite_quads_top
// Turns line and rectangle commands into oriented sprite quads.
// ----------------------------------------------------------------------------
// Quad setup handles one command at a time and is paced by the one iterative
// CORDIC unit that serves both the angle/length and sin/cos passes; the command
// queue can take new commands meanwhile. An outlined rectangle takes one
// sin/cos pass and then four line passes.
// Reset: synchronous rst empties both queues and clears region_valid.
module shape_primitive_to_sprite_quads_top
  import spq_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter int CMD_DEPTH    = CMD_DEPTH_DEF,
  parameter int OUT_DEPTH    = OUT_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // configuration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data,
  // command side
  input  logic               push,
  output logic               full,
  input  logic [1:0]         op,
  input  logic signed [31:0] coord_a_x,
  input  logic signed [31:0] coord_a_y,
  input  logic signed [31:0] coord_b_x,
  input  logic signed [31:0] coord_b_y,
  input  logic signed [15:0] rotation_angle,
  input  logic [30:0]        thickness,
  input  logic [31:0]        rgba_color,
  input  logic [15:0]        draw_depth,
  // result side
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] sprite_x,
  output logic signed [31:0] sprite_y,
  output logic signed [31:0] sprite_w,
  output logic signed [31:0] sprite_h,
  output logic signed [15:0] sprite_angle,
  output logic [31:0]        sprite_color,
  output logic [15:0]        sprite_depth,
  output logic               last
);

  cmd_t  cmd_in;
  cmd_t  q_cmd;
  cmd_t  back_cmd;
  logic  q_push;
  logic  q_full;
  logic  q_empty;
  logic  q_pop;
  logic [$bits(cmd_t)-1:0] q_rdata;

  quad_t back_quad;
  quad_t res_quad;
  logic  res_push;
  logic  res_full;
  logic [$bits(quad_t)-1:0] res_rdata;

  // pack the command fields
  always_comb begin
    cmd_in.op    = op;
    cmd_in.ax    = coord_a_x;
    cmd_in.ay    = coord_a_y;
    cmd_in.bx    = coord_b_x;
    cmd_in.by    = coord_b_y;
    cmd_in.rot   = rotation_angle;
    cmd_in.thick = thickness;
    cmd_in.color = rgba_color;
    cmd_in.depth = draw_depth;
  end

  // front: region register, drop of undrawn commands
  spq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .cmd_in    (cmd_in),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  // command queue decouples acceptance from quad setup
  spq_fifo #(.WIDTH($bits(cmd_t)), .DEPTH(CMD_DEPTH)) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_cmd),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign back_cmd = cmd_t'(q_rdata);

  // back: CORDIC and multiply sequencer
  spq_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (q_empty),
    .cmd_in    (back_cmd),
    .cmd_pop   (q_pop),
    .out_full  (res_full),
    .out_push  (res_push),
    .out_quad  (back_quad)
  );

  // result queue holds finished quads until transfer
  spq_fifo #(.WIDTH($bits(quad_t)), .DEPTH(OUT_DEPTH)) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (back_quad),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty)
  );

  assign res_quad     = quad_t'(res_rdata);
  assign sprite_x     = res_quad.x;
  assign sprite_y     = res_quad.y;
  assign sprite_w     = res_quad.w;
  assign sprite_h     = res_quad.h;
  assign sprite_angle = res_quad.angle;
  assign sprite_color = res_quad.color;
  assign sprite_depth = res_quad.depth;
  assign last         = res_quad.last;

endmodule

[hw/rtl/spq_fifo.sv]
// ----------------------------------------------------------------------------
// spq_fifo
// Small show-ahead queue; push is dropped when full, pop when empty.
// ----------------------------------------------------------------------------
module spq_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W:0]   wr_ptr;
  logic [PTR_W:0]   rd_ptr;

  assign empty = (wr_ptr == rd_ptr);
  assign full  = (wr_ptr[PTR_W] != rd_ptr[PTR_W]) &&
                 (wr_ptr[PTR_W-1:0] == rd_ptr[PTR_W-1:0]);
  assign rdata = mem[rd_ptr[PTR_W-1:0]];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr[PTR_W-1:0]] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

endmodule

[hw/rtl/spq_cordic.sv]
// ----------------------------------------------------------------------------
// spq_cordic
// Iterative CORDIC, one step per cycle, rotation or vectoring mode.
// ----------------------------------------------------------------------------
module spq_cordic
  import spq_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  cordic_req_t req,
  output cordic_rsp_t rsp
);

  localparam int STEP_W = $clog2(CORDIC_STEPS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

  logic                 busy;
  logic                 done;
  logic                 vec;
  logic                 flip;
  logic                 special;
  logic [STEP_W-1:0]    cnt;
  logic signed [CW-1:0] x;
  logic signed [CW-1:0] y;
  logic signed [ZW-1:0] z;

  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic signed [ZW-1:0] at;
  logic [31:0]          a_turn;
  logic                 a_flip;

  assign xs     = x >>> cnt;
  assign ys     = y >>> cnt;
  assign at     = signed'({2'b00, atan_val(5'(cnt))});
  assign a_flip = (req.a[31:30] == 2'd1) || (req.a[31:30] == 2'd2);
  assign a_turn = a_flip ? (req.a + 32'h8000_0000) : req.a;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == LAST_STEP);
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      vec <= req.vec;
      if (req.vec) begin
        special <= (req.x == '0) && (req.y == '0);
        flip    <= 1'b0;
        if (req.x[CW-1]) begin
          x <= -req.x;
          y <= -req.y;
          z <= signed'({2'b00, 32'h8000_0000});
        end else begin
          x <= req.x;
          y <= req.y;
          z <= '0;
        end
      end else begin
        special <= (req.a == 32'h0);
        flip    <= a_flip;
        x       <= GAIN_Q30;
        y       <= '0;
        z       <= signed'({{2{a_turn[31]}}, a_turn});
      end
    end else if (busy) begin
      if (vec) begin
        if (!y[CW-1]) begin
          x <= x + ys;
          y <= y - xs;
          z <= z + at;
        end else begin
          x <= x - ys;
          y <= y + xs;
          z <= z - at;
        end
      end else begin
        if (!z[ZW-1]) begin
          x <= x - ys;
          y <= y + xs;
          z <= z - at;
        end else begin
          x <= x + ys;
          y <= y - xs;
          z <= z + at;
        end
      end
    end
  end

  always_comb begin
    rsp.done = done;
    rsp.z    = (vec && special) ? '0 : z;
    if (vec) begin
      rsp.x = special ? '0 : x;
      rsp.y = y;
    end else if (special) begin
      rsp.x = ONE_Q30;
      rsp.y = '0;
    end else begin
      rsp.x = flip ? -x : x;
      rsp.y = flip ? -y : y;
    end
  end

endmodule

[hw/rtl/spq_front.sv]
// ----------------------------------------------------------------------------
// spq_front
// Holds the region register, accepts commands and drops those not drawn.
// ----------------------------------------------------------------------------
module spq_front
  import spq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_data,
  input  logic push,
  output logic full,
  input  cmd_t cmd_in,
  input  logic q_full,
  output logic q_push,
  output cmd_t q_cmd
);

  logic region_valid;
  logic keep;

  assign cfg_ready = 1'b1;
  assign full      = q_full;
  assign keep      = region_valid &&
                     ((cmd_in.op == OP_LINE) || (cmd_in.op == OP_FILL) ||
                      (cmd_in.op == OP_OUTLINE));
  assign q_push    = push && !q_full && keep;
  assign q_cmd     = cmd_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_valid <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      region_valid <= cfg_data;
    end
  end

endmodule

[hw/rtl/spq_back.sv]
// ----------------------------------------------------------------------------
// spq_back
// Sequencer over a shared CORDIC and a shared multiplier that emits quads.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spq_back
  import spq_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  cmd_empty,
  input  cmd_t  cmd_in,
  output logic  cmd_pop,
  input  logic  out_full,
  output logic  out_push,
  output quad_t out_quad
);

  back_state_t state, state_next;
  cordic_req_t creq;
  cordic_rsp_t crsp;

  cmd_t                 cmd;
  logic [2:0]           mcnt;
  logic [1:0]           ccnt;
  logic [1:0]           lcnt;
  logic [1:0]           pidx;
  logic signed [MW-1:0] c_q;
  logic signed [MW-1:0] s_q;
  logic signed [MW-1:0] mul_a;
  logic signed [MW-1:0] mul_b;
  logic signed [PW-1:0] mul_p;
  logic signed [PW-1:0] prod [4];
  logic signed [31:0]   cx [4];
  logic signed [31:0]   cy [4];
  logic signed [CW-1:0] vx_q;
  logic [15:0]          ang_q;
  logic signed [31:0]   len_q;

  logic signed [AW-1:0] ex;
  logic signed [AW-1:0] ey;
  logic signed [AW-1:0] fx;
  logic signed [AW-1:0] fy;
  logic signed [AW-1:0] lx;
  logic signed [AW-1:0] ly;
  logic signed [AW-1:0] lsum;
  logic signed [AW-1:0] lsh;
  logic signed [31:0]   px_new;
  logic signed [31:0]   py_new;
  logic signed [AW-1:0] rnd;
  logic                 sx_pos;
  logic                 sy_pos;

  spq_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk (clk),
    .rst (rst),
    .req (creq),
    .rsp (crsp)
  );

  assign pidx   = 2'(mcnt - 3'd1);
  assign rnd    = AW'(ONE_Q30);
  assign sx_pos = (ccnt == 2'd1) || (ccnt == 2'd2);
  assign sy_pos = ccnt[1];

  // corner i of the outline
  assign ex = (AW'(cmd.bx) <<< 30) + (sx_pos ? AW'(prod[0]) : -AW'(prod[0]))
              - (sy_pos ? AW'(prod[3]) : -AW'(prod[3])) + rnd;
  assign ey = (AW'(cmd.by) <<< 30) + (sx_pos ? AW'(prod[1]) : -AW'(prod[1]))
              + (sy_pos ? AW'(prod[2]) : -AW'(prod[2])) + rnd;
  assign px_new = sat32(SAT_W'(cmd.ax) + SAT_W'(ex >>> 31));
  assign py_new = sat32(SAT_W'(cmd.ay) + SAT_W'(ey >>> 31));

  // filled rectangle origin
  assign fx = (AW'(cmd.bx) <<< 30) - AW'(prod[0]) + AW'(prod[3]) + rnd;
  assign fy = (AW'(cmd.by) <<< 30) - AW'(prod[2]) - AW'(prod[1]) + rnd;

  // line origin offset by half thickness
  assign lx = AW'(prod[0]) + rnd;
  assign ly = rnd - AW'(prod[1]);

  assign lsum = (AW'(prod[1]) <<< 18) + AW'(prod[0]) + AW'(39'sd536870912);
  assign lsh  = lsum >>> 30;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (!cmd_empty) begin
          state_next = (cmd_in.op == OP_LINE) ? ST_VEC_GO : ST_RROT_GO;
        end
      end
      ST_RROT_GO:   state_next = ST_RROT_WAIT;
      ST_RROT_WAIT: if (crsp.done) state_next = ST_RECT_MUL;
      ST_RECT_MUL: begin
        if (mcnt == 3'd4) begin
          state_next = (cmd.op == OP_FILL) ? ST_FILL : ST_CORNER;
        end
      end
      ST_FILL:      if (!out_full) state_next = ST_IDLE;
      ST_CORNER:    if (ccnt == 2'd3) state_next = ST_VEC_GO;
      ST_VEC_GO:    state_next = ST_VEC_WAIT;
      ST_VEC_WAIT:  if (crsp.done) state_next = ST_LEN_MUL;
      ST_LEN_MUL:   if (mcnt == 3'd2) state_next = ST_LROT_GO;
      ST_LROT_GO:   state_next = ST_LROT_WAIT;
      ST_LROT_WAIT: if (crsp.done) state_next = ST_T_MUL;
      ST_T_MUL:     if (mcnt == 3'd2) state_next = ST_EMIT;
      ST_EMIT: begin
        if (!out_full) begin
          state_next = (lcnt == 2'd3) ? ST_IDLE : ST_VEC_GO;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop    = 1'b0;
    out_push   = 1'b0;
    creq.start = 1'b0;
    creq.vec   = (state == ST_VEC_GO);
    creq.x     = CW'(cx[1]) - CW'(cx[0]);
    creq.y     = CW'(cy[1]) - CW'(cy[0]);
    creq.a     = (state == ST_LROT_GO) ? {ang_q, 16'h0} : {cmd.rot, 16'h0};
    mul_a      = '0;
    mul_b      = '0;
    out_quad.x     = sat32(SAT_W'(cx[0]) + SAT_W'(lx >>> 31));
    out_quad.y     = sat32(SAT_W'(cy[0]) + SAT_W'(ly >>> 31));
    out_quad.w     = len_q;
    out_quad.h     = signed'({1'b0, cmd.thick});
    out_quad.angle = signed'(ang_q);
    out_quad.color = cmd.color;
    out_quad.depth = cmd.depth;
    out_quad.last  = (lcnt == 2'd3);
    case (state)
      ST_IDLE:    cmd_pop = !cmd_empty;
      ST_RROT_GO: creq.start = 1'b1;
      ST_VEC_GO:  creq.start = 1'b1;
      ST_LROT_GO: creq.start = 1'b1;
      ST_RECT_MUL: begin
        mul_a = mcnt[1] ? MW'(cmd.by) : MW'(cmd.bx);
        mul_b = mcnt[0] ? s_q : c_q;
      end
      ST_LEN_MUL: begin
        mul_a = mcnt[0] ? MW'({1'b0, vx_q[35:18]}) : MW'({1'b0, vx_q[17:0]});
        mul_b = MW'(GAIN_Q30);
      end
      ST_T_MUL: begin
        mul_a = MW'({1'b0, cmd.thick});
        mul_b = mcnt[0] ? c_q : s_q;
      end
      ST_FILL: begin
        out_push       = !out_full;
        out_quad.x     = sat32(SAT_W'(cmd.ax) + SAT_W'(fx >>> 31));
        out_quad.y     = sat32(SAT_W'(cmd.ay) + SAT_W'(fy >>> 31));
        out_quad.w     = cmd.bx;
        out_quad.h     = cmd.by;
        out_quad.angle = cmd.rot;
        out_quad.last  = 1'b1;
      end
      ST_EMIT: out_push = !out_full;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      mcnt  <= '0;
      ccnt  <= '0;
      lcnt  <= '0;
    end else begin
      state <= state_next;
      if ((state == ST_RECT_MUL) || (state == ST_LEN_MUL) || (state == ST_T_MUL)) begin
        mcnt <= (state_next == state) ? mcnt + 1'b1 : 3'd0;
      end else begin
        mcnt <= '0;
      end
      ccnt <= (state == ST_CORNER) ? ccnt + 1'b1 : 2'd0;
      if (cmd_pop) begin
        lcnt <= (cmd_in.op == OP_LINE) ? 2'd3 : 2'd0;
      end else if ((state == ST_EMIT) && !out_full) begin
        lcnt <= lcnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    mul_p <= PW'(mul_a) * PW'(mul_b);
    case (state)
      ST_IDLE: begin
        if (cmd_pop) begin
          cmd   <= cmd_in;
          cx[0] <= cmd_in.ax;
          cy[0] <= cmd_in.ay;
          cx[1] <= cmd_in.bx;
          cy[1] <= cmd_in.by;
        end
      end
      ST_RROT_WAIT, ST_LROT_WAIT: begin
        if (crsp.done) begin
          c_q <= MW'(crsp.x);
          s_q <= MW'(crsp.y);
        end
      end
      ST_RECT_MUL, ST_LEN_MUL, ST_T_MUL: begin
        if (mcnt != 3'd0) begin
          prod[pidx] <= mul_p;
        end
      end
      ST_CORNER: begin
        cx[ccnt] <= px_new;
        cy[ccnt] <= py_new;
      end
      ST_VEC_WAIT: begin
        if (crsp.done) begin
          vx_q  <= crsp.x;
          ang_q <= crsp.z[31:16] + {15'h0, crsp.z[15]};
        end
      end
      ST_LROT_GO: begin
        len_q <= (lsh > AW'(32'sh7FFFFFFF)) ? 32'sh7FFFFFFF : lsh[31:0];
      end
      ST_EMIT: begin
        // advance to the next edge of the outline
        if (!out_full) begin
          cx[0] <= cx[1];
          cx[1] <= cx[2];
          cx[2] <= cx[3];
          cx[3] <= cx[0];
          cy[0] <= cy[1];
          cy[1] <= cy[2];
          cy[2] <= cy[3];
          cy[3] <= cy[0];
        end
      end
      default: ;
    endcase
  end

  `ASSERT_IMP(a_push_room, clk, rst, out_push, !out_full)
  `ASSERT_IMP(a_done_wait, clk, rst, crsp.done, (state == ST_RROT_WAIT) || (state == ST_LROT_WAIT) || (state == ST_VEC_WAIT))
  `ASSERT_NXT(a_last_idle, clk, rst, out_push && out_quad.last, state == ST_IDLE)

endmodule

[test/spq_quad_checker.sv]
// ----------------------------------------------------------------------------
// spq_quad_checker
// Watches the command, result and configuration channels of the sprite quad
// setup block, predicts the quads of every accepted command in fixed point
// and compares each popped quad with the oldest prediction.
// ----------------------------------------------------------------------------
module spq_quad_checker
  import spq_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic               cfg_data,
  input  logic               push,
  input  logic               full,
  input  logic [1:0]         op,
  input  logic signed [31:0] coord_a_x,
  input  logic signed [31:0] coord_a_y,
  input  logic signed [31:0] coord_b_x,
  input  logic signed [31:0] coord_b_y,
  input  logic signed [15:0] rotation_angle,
  input  logic [30:0]        thickness,
  input  logic [31:0]        rgba_color,
  input  logic [15:0]        draw_depth,
  input  logic               empty,
  input  logic               pop,
  input  logic signed [31:0] sprite_x,
  input  logic signed [31:0] sprite_y,
  input  logic signed [31:0] sprite_w,
  input  logic signed [31:0] sprite_h,
  input  logic signed [15:0] sprite_angle,
  input  logic [31:0]        sprite_color,
  input  logic [15:0]        sprite_depth,
  input  logic               last,
  output int                 fail_count,
  output int                 quads_pending,
  output int                 quads_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint UNIT_Q30 = 64'sd1073741824;
  localparam longint GAIN     = 64'sd652032874;

  const longint arc_step[24] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
    64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};

  logic  region_set;
  quad_t quad_q[$];

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Q2.30 cosine and sine of a 32-bit binary angle.
  function automatic void cordic_sincos(input bit [31:0] a, output longint c,
                                        output longint s);
    bit     flip;
    longint x, y, z, xs, ys;
    flip = 0;
    x = GAIN;
    y = 0;
    if (a == 0) begin
      c = UNIT_Q30;
      s = 0;
      return;
    end
    if (a[31:30] == 2'd1 || a[31:30] == 2'd2) begin
      a = a + 32'h80000000;
      flip = 1;
    end
    z = a[31] ? longint'(a) - (64'sd1 <<< 32) : longint'(a);
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= arc_step[i];
      end else begin
        x += ys; y -= xs; z += arc_step[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // Length and 16-bit binary angle of the vector (dx, dy).
  function automatic void cordic_vector(input longint dx, input longint dy,
                                        output longint len, output bit [15:0] ang);
    longint    x, y, xs, ys;
    bit [31:0] z, zr;
    bit [63:0] p;
    x = dx;
    y = dy;
    z = 0;
    if (dx == 0 && dy == 0) begin
      len = 0;
      ang = 0;
      return;
    end
    if (dx < 0) begin
      x = -dx; y = -dy; z = 32'h80000000;
    end
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += 32'(arc_step[i]);
      end else begin
        x -= ys; y += xs; z -= 32'(arc_step[i]);
      end
    end
    p = (64'(x) * 64'(GAIN) + 64'd536870912) >> 30;
    len = (p > 64'd2147483647) ? 64'sd2147483647 : longint'(p);
    zr = z + 32'h8000;
    ang = zr[31:16];
  endfunction

  function automatic quad_t make_quad(input longint x, input longint y,
                                      input longint w, input longint h,
                                      input bit [15:0] ang, input bit [31:0] col,
                                      input bit [15:0] dep, input bit fin);
    quad_t q;
    q.x = 32'(clamp32(x));
    q.y = 32'(clamp32(y));
    q.w = 32'(clamp32(w));
    q.h = 32'(clamp32(h));
    q.angle = ang;
    q.color = col;
    q.depth = dep;
    q.last = fin;
    return q;
  endfunction

  function automatic quad_t segment_quad(input longint x0, input longint y0,
                                         input longint x1, input longint y1,
                                         input longint t, input bit [31:0] col,
                                         input bit [15:0] dep, input bit fin);
    longint    len, c, s;
    bit [15:0] ang;
    cordic_vector(x1 - x0, y1 - y0, len, ang);
    cordic_sincos({ang, 16'h0}, c, s);
    return make_quad(x0 + ((t * s + UNIT_Q30) >>> 31), y0 + ((UNIT_Q30 - t * c) >>> 31),
                     len, t, ang, col, dep, fin);
  endfunction

  // Append the quads of one accepted command to the expected queue.
  task automatic predict_quads();
    longint ax, ay, bx, by, t, c, s, dx, dy;
    longint px[4], py[4];
    int     sgx[4], sgy[4];
    sgx = '{-1, 1, 1, -1};
    sgy = '{-1, -1, 1, 1};
    ax = coord_a_x; ay = coord_a_y; bx = coord_b_x; by = coord_b_y;
    t = longint'(thickness);
    if (!region_set) return;
    case (op)
      OP_LINE: begin
        quad_q.push_back(segment_quad(ax, ay, bx, by, t, rgba_color, draw_depth, 1'b1));
      end
      OP_FILL: begin
        cordic_sincos({rotation_angle, 16'h0}, c, s);
        quad_q.push_back(make_quad(
            ax + ((bx * (UNIT_Q30 - c) + by * s + UNIT_Q30) >>> 31),
            ay + ((by * (UNIT_Q30 - c) - bx * s + UNIT_Q30) >>> 31),
            bx, by, rotation_angle, rgba_color, draw_depth, 1'b1));
      end
      OP_OUTLINE: begin
        cordic_sincos({rotation_angle, 16'h0}, c, s);
        for (int i = 0; i < 4; i++) begin
          dx = sgx[i] * bx;
          dy = sgy[i] * by;
          px[i] = clamp32(ax + ((bx * UNIT_Q30 + dx * c - dy * s + UNIT_Q30) >>> 31));
          py[i] = clamp32(ay + ((by * UNIT_Q30 + dx * s + dy * c + UNIT_Q30) >>> 31));
        end
        for (int i = 0; i < 4; i++) begin
          quad_q.push_back(segment_quad(px[i], py[i], px[(i + 1) % 4], py[(i + 1) % 4],
                                        t, rgba_color, draw_depth, i == 3));
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    quad_t want, got;
    if (rst) begin
      region_set = 0;
      quad_q.delete();
      fail_count = 0;
      quads_checked = 0;
    end else begin
      if (cfg_valid && cfg_ready) region_set = cfg_data;
      if (push && !full) predict_quads();
      if (pop && !empty) begin
        got = '{sprite_x, sprite_y, sprite_w, sprite_h, sprite_angle, sprite_color,
                sprite_depth, last};
        if (quad_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("%0t: unexpected quad %p", $realtime, got);
        end else begin
          want = quad_q.pop_front();
          quads_checked++;
          if (got.x !== want.x || got.y !== want.y || got.w !== want.w ||
              got.h !== want.h || got.angle !== want.angle ||
              got.color !== want.color || got.depth !== want.depth ||
              got.last !== want.last) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: quad mismatch\n  exp %p\n  got %p", $realtime, want, got);
          end
        end
      end
    end
    quads_pending = quad_q.size();
  end

endmodule

[test/tb_shape_primitive_to_sprite_quads_top.sv]
// ----------------------------------------------------------------------------
// tb_shape_primitive_to_sprite_quads_top
// Drives line and rectangle commands into the sprite quad setup block under
// varied idling on both queues, toggles the pixel region register and lets a
// checker module compare every quad.
// ----------------------------------------------------------------------------
module tb_shape_primitive_to_sprite_quads_top;
  import spq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 300;   // margin for an outlined rectangle to finish
  localparam int STALL_LIMIT   = 6000;  // cycles with no transfer at all
  localparam int LONG_HOLD     = 400;

  logic               clk, rst;
  logic               cfg_valid, cfg_ready, cfg_data;
  logic               push, full, empty, pop, last;
  logic [1:0]         op;
  logic signed [31:0] coord_a_x, coord_a_y, coord_b_x, coord_b_y;
  logic signed [15:0] rotation_angle;
  logic [30:0]        thickness;
  logic [31:0]        rgba_color;
  logic [15:0]        draw_depth;
  logic signed [31:0] sprite_x, sprite_y, sprite_w, sprite_h;
  logic signed [15:0] sprite_angle;
  logic [31:0]        sprite_color;
  logic [15:0]        sprite_depth;

  int fail_count, quads_pending, quads_checked;
  int send_idle_pct, pop_stall_pct, cmds_sent, quiet_cycles;
  bit hold_pop;

  shape_primitive_to_sprite_quads_top dut (.*);
  spq_quad_checker chk (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Abort when neither queue nor the register channel moves for too long.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    pop = 0;
    forever begin
      @(posedge clk);
      if (hold_pop) begin
        pop <= 0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_pop = 0;
      end else begin
        pop <= ($urandom_range(0, 99) >= pop_stall_pct);
      end
    end
  end

  // Offer one command; hold it until the block takes it.
  task automatic send_cmd(input cmd_t c);
    if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      push <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    push <= 1;
    op <= c.op;
    coord_a_x <= c.ax;
    coord_a_y <= c.ay;
    coord_b_x <= c.bx;
    coord_b_y <= c.by;
    rotation_angle <= c.rot;
    thickness <= c.thick;
    rgba_color <= c.color;
    draw_depth <= c.depth;
    do @(posedge clk); while (full);
    cmds_sent++;
  endtask

  task automatic drain();
    push <= 0;
    while (quads_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the region register only once the block has gone quiet.
  task automatic write_region(input logic v);
    drain();
    cfg_valid <= 1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h7FFFFFFF)) >>> $urandom_range(0, 24);
      default: return int'($urandom_range(0, 32'h01000000)) - 32'sh00800000;
    endcase
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    int   pick;
    pick = $urandom_range(0, 19);
    c.op = (pick < 7) ? OP_LINE : (pick < 13) ? OP_FILL : (pick < 19) ? OP_OUTLINE : 2'd3;
    c.ax = rand_coord();
    c.ay = rand_coord();
    c.bx = rand_coord();
    c.by = rand_coord();
    c.rot = $urandom;
    c.thick = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 32'h80000));
    c.color = $urandom;
    c.depth = $urandom;
    return c;
  endfunction

  task automatic run_random(input int n, input int idle_pct, input int stall_pct);
    send_idle_pct = idle_pct;
    pop_stall_pct = stall_pct;
    repeat (n) send_cmd(rand_cmd());
  endtask

  function automatic cmd_t mk(input logic [1:0] o, input int ax, input int ay,
                              input int bx, input int by, input logic [15:0] rot,
                              input logic [30:0] th);
    cmd_t c;
    c = '{o, ax, ay, bx, by, rot, th, 32'hFFFFFFFF, 16'hFFFF};
    return c;
  endfunction

  initial begin
    cmd_t dir_q[$];
    rst = 1;
    cfg_valid = 0;
    cfg_data = 0;
    push = 0;
    op = OP_LINE;
    coord_a_x = 0; coord_a_y = 0; coord_b_x = 0; coord_b_y = 0;
    rotation_angle = 0; thickness = 0; rgba_color = 0; draw_depth = 0;
    hold_pop = 0;
    send_idle_pct = 0;
    pop_stall_pct = 0;
    cmds_sent = 0;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Region not set yet: every command must vanish.
    run_random(8, 0, 0);
    write_region(1'b1);

    // Directed: zero-length line, extremes, every op, unused op, angle corners.
    dir_q = '{
      mk(OP_LINE, 0, 0, 0, 0, 16'h0000, 31'h10000),
      mk(OP_LINE, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0,
         31'h7FFFFFFF),
      mk(OP_LINE, 32'sh7FFFFFFF, 0, 32'sh80000000, 32'sh00010000, 0, 31'h0),
      mk(OP_LINE, 32'h00100000, 32'h00100000, 32'h00000000, 32'h00200000, 0, 31'h20000),
      mk(OP_LINE, 0, 0, 0, -32'sh00050000, 0, 31'h8000),
      mk(OP_FILL, 32'h00100000, 32'h00080000, 32'h00400000, 32'h00200000, 16'h0000,
         31'h0),
      mk(OP_FILL, 32'h00100000, 32'h00080000, 32'h00400000, 32'h00200000, 16'h8000,
         31'h0),
      mk(OP_FILL, 0, 0, 32'h00400000, 32'h00200000, 16'h4000, 31'h0),
      mk(OP_FILL, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 16'h7FFF,
         31'h0),
      mk(OP_FILL, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 16'hC000,
         31'h0),
      mk(OP_OUTLINE, 0, 0, 32'h00400000, 32'h00200000, 16'h0000, 31'h10000),
      mk(OP_OUTLINE, 32'h01000000, 32'h00800000, 32'h00400000, 32'h00200000, 16'h2000,
         31'h7FFFFFFF),
      mk(OP_OUTLINE, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 16'h8001,
         31'h0),
      mk(OP_OUTLINE, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 16'hFFFF,
         31'h1),
      mk(OP_OUTLINE, 0, 0, 0, 0, 16'h4000, 31'h10000),
      mk(2'd3, 32'h1234, 32'h5678, 32'h9ABC, 32'hDEF0, 16'h1111, 31'h100)
    };
    foreach (dir_q[i]) send_cmd(dir_q[i]);

    // Random phases: free flow, sparse sender, slow receiver, both.
    run_random(35, 0, 0);
    run_random(30, 69, 0);
    run_random(30, 0, 69);
    run_random(25, 19, 19);

    // Back-pressure: stop popping for a long stretch while commands keep coming.
    send_idle_pct = 0;
    pop_stall_pct = 0;
    hold_pop = 1;
    repeat (12) send_cmd(rand_cmd());

    write_region(1'b0);
    run_random(8, 19, 19);
    write_region(1'b1);
    run_random(25, 19, 19);

    drain();
    $display("Ran %0d commands, %0d quads compared, region register toggled 0/1/0/1.",
             cmds_sent, quads_checked);
    if (fail_count == 0 && quads_pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/spq_pkg.sv
hw/rtl/spq_fifo.sv
hw/rtl/spq_cordic.sv
hw/rtl/spq_front.sv
hw/rtl/spq_back.sv
hw/rtl/shape_primitive_to_sprite_quads_top.sv
test/spq_quad_checker.sv
test/tb_shape_primitive_to_sprite_quads_top.sv
